// File: rtl/core/stbs_pkg.sv
// Shared types and constants for the sorted table search block.
// No dependencies.
`default_nettype none
package stbs_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int ACC_W     = 4;
  localparam int CNT_W     = 5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/sorted_table_binary_search.sv
// Top level: size register, table memory and search sequencer.
// Depends on stbs_pkg, stbs_mem, stbs_ctrl.
//
//   channel  | handshake                 | payload
//   in       | in_valid / in_ready       | cmd, index, key
//   out      | out_valid / out_ready     | found, position, accesses
//   cfg      | cfg_we                    | cfg_wdata (table_size)
//
// Search: up to 11 probes at DEPTH 1024, one probe per cycle on the single
// table read port, then via the result register into the output register.
// New items are taken only while idle: not while a search runs or a result waits.
// The result register frees the sequencer as soon as the result is handed over.
// Reset clears the size register and control; table contents are kept.
`default_nettype none
module sorted_table_binary_search #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [stbs_pkg::SIZE_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic [stbs_pkg::IDX_W-1:0]        index,
  input  wire logic signed [stbs_pkg::KEY_W-1:0] key,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   found,
  output logic      [stbs_pkg::IDX_W-1:0]        position,
  output logic      [stbs_pkg::ACC_W-1:0]        accesses
);

  localparam int AW = $clog2(DEPTH);

  logic [stbs_pkg::SIZE_W-1:0] table_size;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [stbs_pkg::KEY_W-1:0]  mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [stbs_pkg::KEY_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  stbs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbs_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .table_size (table_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .index      (index),
    .key        (key),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .position   (position),
    .accesses   (accesses)
  );

endmodule
`default_nettype wire

// File: rtl/core/stbs_mem.sv
// Table storage: one write port and one registered read port.
// Depends on stbs_pkg.
`default_nettype none
module stbs_mem #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [stbs_pkg::KEY_W-1:0]   wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [stbs_pkg::KEY_W-1:0]   rdata
);

  logic [stbs_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/stbs_ctrl.sv
// Search sequencer: one probe per cycle against the table memory, result register.
// Depends on stbs_pkg; drives stbs_mem.
`default_nettype none
module stbs_ctrl #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [stbs_pkg::SIZE_W-1:0]       table_size,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic [stbs_pkg::IDX_W-1:0]        index,
  input  wire logic signed [stbs_pkg::KEY_W-1:0] key,
  output logic                                   mem_we,
  output logic      [AW-1:0]                     mem_waddr,
  output logic      [stbs_pkg::KEY_W-1:0]        mem_wdata,
  output logic      [AW-1:0]                     mem_raddr,
  input  wire logic [stbs_pkg::KEY_W-1:0]        mem_rdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   found,
  output logic      [stbs_pkg::IDX_W-1:0]        position,
  output logic      [stbs_pkg::ACC_W-1:0]        accesses
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW > stbs_pkg::SIZE_W) ? CW : stbs_pkg::SIZE_W;
  localparam logic [stbs_pkg::CNT_W-1:0] SAT = stbs_pkg::CNT_W'((1 << stbs_pkg::ACC_W) - 1);

  stbs_pkg::state_t state, state_next;

  logic [CW-1:0]                        lo, lo_next;
  logic [CW-1:0]                        hi1, hi1_next;
  logic [AW-1:0]                        mid, mid_next;
  logic [stbs_pkg::CNT_W-1:0]           count, count_next;
  logic signed [stbs_pkg::KEY_W-1:0]    skey;
  logic                                 res_found, res_found_next;
  logic [stbs_pkg::IDX_W-1:0]           res_pos, res_pos_next;
  logic [stbs_pkg::CNT_W-1:0]           res_cnt, res_cnt_next;

  logic                                 accept;
  logic                                 out_load;
  logic [SW-1:0]                        ts_ext;
  logic [CW-1:0]                        n;
  logic [CW-1:0]                        n_m1;
  logic [AW-1:0]                        mid0;
  logic signed [stbs_pkg::KEY_W-1:0]    v;
  logic [CW-1:0]                        mid_ext;
  logic [CW:0]                          sum;
  logic [31:0]                          mid32;
  logic [31:0]                          idx32;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == stbs_pkg::ST_IDLE);
  assign out_load = (state == stbs_pkg::ST_DONE) && (!out_valid || out_ready);

  // effective size clamped to the table depth
  assign ts_ext = SW'(table_size);
  assign n      = (ts_ext > SW'(DEPTH)) ? CW'(DEPTH) : CW'(ts_ext);
  assign n_m1   = n - CW'(1);
  assign mid0   = AW'(n_m1 >> 1);

  assign v       = $signed(mem_rdata);
  assign mid_ext = CW'(mid);
  assign mid32   = 32'(mid);
  assign idx32   = 32'(index);

  assign mem_we    = accept && (cmd == stbs_pkg::CMD_LOAD) && (idx32 < 32'(DEPTH));
  assign mem_waddr = idx32[AW-1:0];
  assign mem_wdata = key;

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi1_next       = hi1;
    mid_next       = mid;
    count_next     = count;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    res_cnt_next   = res_cnt;
    sum            = '0;
    mem_raddr      = mid;
    case (state)
      stbs_pkg::ST_IDLE: begin
        mem_raddr = mid0;
        if (accept && (cmd == stbs_pkg::CMD_SEARCH)) begin
          if (n == '0) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            res_cnt_next   = stbs_pkg::CNT_W'(1);
            state_next     = stbs_pkg::ST_DONE;
          end else begin
            lo_next    = '0;
            hi1_next   = n;
            mid_next   = mid0;
            count_next = stbs_pkg::CNT_W'(1);
            state_next = stbs_pkg::ST_SRCH;
          end
        end
      end
      stbs_pkg::ST_SRCH: begin
        if (v == skey) begin
          res_found_next = 1'b1;
          res_pos_next   = mid32[stbs_pkg::IDX_W-1:0];
          res_cnt_next   = count;
          state_next     = stbs_pkg::ST_DONE;
        end else begin
          if (v < skey) begin
            lo_next = mid_ext + CW'(1);
          end else begin
            hi1_next = mid_ext;
          end
          sum        = (CW + 1)'(lo_next) + (CW + 1)'(hi1_next) - (CW + 1)'(1);
          mid_next   = AW'(sum >> 1);
          mem_raddr  = mid_next;
          count_next = (count == SAT) ? SAT : count + stbs_pkg::CNT_W'(1);
          if (lo_next >= hi1_next) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            res_cnt_next   = count_next;
            state_next     = stbs_pkg::ST_DONE;
          end
        end
      end
      stbs_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stbs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi1       <= hi1_next;
    mid       <= mid_next;
    count     <= count_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    res_cnt   <= res_cnt_next;
    if (accept) begin
      skey <= key;
    end
    if (out_load) begin
      found    <= res_found;
      position <= res_pos;
      accesses <= (res_cnt > SAT) ? stbs_pkg::ACC_W'(SAT) : stbs_pkg::ACC_W'(res_cnt);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/stbs_checker.sv
// Port-level checks for sorted_table_binary_search, bound to the top level.
// Depends on stbs_pkg.
`default_nettype none
module stbs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          found,
  input wire logic [stbs_pkg::IDX_W-1:0]    position,
  input wire logic [stbs_pkg::ACC_W-1:0]    accesses
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
      && $stable(accesses))
    else $error("result beat changed while stalled");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("miss with nonzero position");

  a_acc_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accesses != '0)
    else $error("zero access count");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .position  (position),
  .accesses  (accesses)
);
`default_nettype wire
